// ----- hw/rtl/smvm_pkg.sv -----
`timescale 1ns / 1ps
package smvm_pkg;

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned VAR_W     = 48;
  localparam int unsigned CNT_OUT_W = 9;
  localparam logic [CNT_OUT_W-1:0] ERR_SAT = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_VAR_SWEEP,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_MED_ADDR,
    ST_MED_LOAD,
    ST_MED_SCAN,
    ST_MED_CHECK,
    ST_DONE
  } smvm_state_e;

endpackage

// ----- hw/rtl/smvm_ram.sv -----
`timescale 1ns / 1ps
module smvm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/smvm_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module smvm_div #(
  parameter int unsigned DW = 56,
  parameter int unsigned NW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned KW = $clog2(DW + 1);

  logic [NW:0]   rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [NW-1:0] dvs_q;
  logic [KW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [NW:0]   trial;
  logic          fits;

  always_comb begin
    trial  = {rem_q[NW-1:0], quo_q[DW-1]};
    fits   = trial >= {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = KW'(DW);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? trial - {1'b0, dvs_q} : trial;
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == KW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/series_mean_variance_median_unit.sv -----
`timescale 1ns / 1ps
// Loading: one sample per cycle, busy_o stays low until a last sample is taken.
// After last, the sample store (one write, one read port) is swept once for the variance
// and once per median candidate; an invalid series skips the sweeps and division.
// Result shows for one cycle on done_o; the receiver cannot stall. No new sample is
// taken before the result has shown. Async reset clears control and the load totals only.
module series_mean_variance_median_unit #(
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [smvm_pkg::SAMPLE_W-1:0]   sample_value_i,
  input  logic                            sample_ok_i,
  input  logic                            last_i,
  output logic                            done_o,
  output logic                            stats_valid_o,
  output logic [smvm_pkg::CNT_OUT_W-1:0]  error_count_o,
  output logic                            overflowed_o,
  output logic [smvm_pkg::CNT_OUT_W-1:0]  sample_count_o,
  output logic [smvm_pkg::SAMPLE_W-1:0]   largest_o,
  output logic [smvm_pkg::SAMPLE_W-1:0]   mean_value_o,
  output logic [smvm_pkg::VAR_W-1:0]      variance_value_o,
  output logic [smvm_pkg::SAMPLE_W-1:0]   median_value_o
);
  import smvm_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_SAMPLES);
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW  = SAMPLE_W + AW;
  localparam int unsigned ACW = VAR_W + AW;

  smvm_state_e state_q, state_d;

  logic [CW-1:0]        cnt_q;
  logic [SW-1:0]        sum_q;
  logic [SAMPLE_W-1:0]  max_q;
  logic [CNT_OUT_W-1:0] bad_q;
  logic                 ovf_q;

  logic [CW-1:0]        j_q;
  logic [CW-1:0]        cand_idx_q;
  logic                 rd_v_q, sq_v_q;
  logic [VAR_W-1:0]     sq_q;
  logic [ACW-1:0]       acc_q;
  logic [SAMPLE_W-1:0]  mean_q, cand_q, med_hi_q, med_lo_q;
  logic [VAR_W-1:0]     var_q;
  logic [CW-1:0]        less_q, eq_q;

  logic                 accept, store_ok, valid;
  logic                 we;
  logic [AW-1:0]        raddr;
  logic [SAMPLE_W-1:0]  rdata;
  logic                 div_start, div_done;
  logic [ACW-1:0]       div_dividend, div_quot;
  logic                 issue, sweep_end;
  logic [SAMPLE_W-1:0]  diff;
  logic [CW-1:0]        k_hi, k_lo;
  logic [CW:0]          upper;
  logic [SAMPLE_W:0]    med_sum;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign store_ok = cnt_q < CW'(MAX_SAMPLES);
  assign we       = accept && sample_ok_i && store_ok;
  assign valid    = (bad_q == '0) && (cnt_q != '0) && !ovf_q;
  assign raddr    = (state_q == ST_MED_ADDR) ? cand_idx_q[AW-1:0] : j_q[AW-1:0];
  assign issue    = ((state_q == ST_VAR_SWEEP) || (state_q == ST_MED_SCAN)) && (j_q < cnt_q);
  assign sweep_end = (j_q == cnt_q) && !rd_v_q && !sq_v_q;
  assign div_start = (state_q == ST_MEAN_GO) || (state_q == ST_VAR_GO);
  assign div_dividend = (state_q == ST_MEAN_GO) ? ACW'(sum_q) : acc_q;
  assign diff     = (rdata >= mean_q) ? rdata - mean_q : mean_q - rdata;
  assign k_hi     = cnt_q >> 1;
  assign k_lo     = k_hi - 1'b1;
  assign upper    = {1'b0, less_q} + {1'b0, eq_q};

  smvm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (sample_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  smvm_div #(
    .DW (ACW),
    .NW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && last_i) begin
          state_d = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        state_d = valid ? ST_MEAN_WAIT : ST_DONE;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          state_d = ST_VAR_SWEEP;
        end
      end
      ST_VAR_SWEEP: begin
        if (sweep_end) begin
          state_d = ST_VAR_GO;
        end
      end
      ST_VAR_GO:    state_d = ST_VAR_WAIT;
      ST_VAR_WAIT: begin
        if (div_done) begin
          state_d = ST_MED_ADDR;
        end
      end
      ST_MED_ADDR:  state_d = ST_MED_LOAD;
      ST_MED_LOAD:  state_d = ST_MED_SCAN;
      ST_MED_SCAN: begin
        if (sweep_end) begin
          state_d = ST_MED_CHECK;
        end
      end
      ST_MED_CHECK: begin
        state_d = (cand_idx_q + 1'b1 == cnt_q) ? ST_DONE : ST_MED_ADDR;
      end
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
      max_q   <= '0;
      bad_q   <= '0;
      ovf_q   <= 1'b0;
      rd_v_q  <= 1'b0;
      sq_v_q  <= 1'b0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue;
      sq_v_q  <= rd_v_q && (state_q == ST_VAR_SWEEP);
      if (issue) begin
        j_q <= j_q + 1'b1;
      end else if ((state_q == ST_MEAN_WAIT) || (state_q == ST_MED_LOAD)) begin
        j_q <= '0;
      end
      if (accept) begin
        if (sample_ok_i) begin
          if (store_ok) begin
            cnt_q <= cnt_q + 1'b1;
            sum_q <= sum_q + SW'(sample_value_i);
            if (sample_value_i > max_q) begin
              max_q <= sample_value_i;
            end
          end else begin
            ovf_q <= 1'b1;
          end
        end else if (bad_q != ERR_SAT) begin
          bad_q <= bad_q + 1'b1;
        end
      end
      if (state_q == ST_DONE) begin
        cnt_q <= '0;
        sum_q <= '0;
        max_q <= '0;
        bad_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MEAN_WAIT) begin
      acc_q      <= '0;
      cand_idx_q <= '0;
      if (div_done) begin
        mean_q <= SAMPLE_W'(div_quot);
      end
    end
    if (rd_v_q && (state_q == ST_VAR_SWEEP)) begin
      sq_q <= diff * diff;
    end
    if (sq_v_q) begin
      acc_q <= acc_q + ACW'(sq_q);
    end
    if ((state_q == ST_VAR_WAIT) && div_done) begin
      var_q <= VAR_W'(div_quot);
    end
    if (state_q == ST_MED_LOAD) begin
      cand_q <= rdata;
      less_q <= '0;
      eq_q   <= '0;
    end
    if (rd_v_q && (state_q == ST_MED_SCAN)) begin
      if (rdata < cand_q) begin
        less_q <= less_q + 1'b1;
      end else if (rdata == cand_q) begin
        eq_q <= eq_q + 1'b1;
      end
    end
    if (state_q == ST_MED_CHECK) begin
      cand_idx_q <= cand_idx_q + 1'b1;
      if ((less_q <= k_hi) && ({1'b0, k_hi} < upper)) begin
        med_hi_q <= cand_q;
      end
      if ((less_q <= k_lo) && ({1'b0, k_lo} < upper)) begin
        med_lo_q <= cand_q;
      end
    end
  end

  assign med_sum = {1'b0, med_hi_q} + {1'b0, med_lo_q};

  assign busy_o           = state_q != ST_IDLE;
  assign done_o           = state_q == ST_DONE;
  assign stats_valid_o    = valid;
  assign error_count_o    = bad_q;
  assign overflowed_o     = ovf_q;
  assign sample_count_o   = CNT_OUT_W'(cnt_q);
  assign largest_o        = valid ? max_q : '0;
  assign mean_value_o     = valid ? mean_q : '0;
  assign variance_value_o = valid ? var_q : '0;
  assign median_value_o   = !valid ? '0 :
                            cnt_q[0] ? med_hi_q : med_sum[SAMPLE_W:1];

endmodule

// ----- hw/rtl/smvm_checker.sv -----
`timescale 1ns / 1ps
module smvm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            last_i,
  input logic                            done_o,
  input logic                            stats_valid_o,
  input logic [smvm_pkg::CNT_OUT_W-1:0]  error_count_o,
  input logic                            overflowed_o,
  input logic [smvm_pkg::CNT_OUT_W-1:0]  sample_count_o,
  input logic [smvm_pkg::SAMPLE_W-1:0]   largest_o,
  input logic [smvm_pkg::SAMPLE_W-1:0]   mean_value_o
);
  import smvm_pkg::*;

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_i |=> busy_o)
    else $error("no busy after last transaction");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("busy held after result");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result while idle");

  a_valid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && stats_valid_o |-> error_count_o == '0 && !overflowed_o && sample_count_o != '0)
    else $error("valid result with errors");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !stats_valid_o |-> largest_o == '0 && mean_value_o == '0)
    else $error("invalid result not zeroed");

endmodule

bind series_mean_variance_median_unit smvm_checker u_smvm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .last_i         (last_i),
  .done_o         (done_o),
  .stats_valid_o  (stats_valid_o),
  .error_count_o  (error_count_o),
  .overflowed_o   (overflowed_o),
  .sample_count_o (sample_count_o),
  .largest_o      (largest_o),
  .mean_value_o   (mean_value_o)
);

// ----- tb/tb_series_mean_variance_median_unit.sv -----
`timescale 1ns / 1ps
module tb_series_mean_variance_median_unit;
  import smvm_pkg::*;

  localparam int unsigned DEPTH = 256;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    bit                  ok;
    bit                  lst;
    bit                  hold;
  } sample_item_t;

  typedef struct {
    logic                 valid;
    logic [CNT_OUT_W-1:0] errors;
    logic                 ovf;
    logic [CNT_OUT_W-1:0] count;
    logic [SAMPLE_W-1:0]  maxv;
    logic [SAMPLE_W-1:0]  mean;
    logic [VAR_W-1:0]     var_v;
    logic [SAMPLE_W-1:0]  med;
  } series_stats_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [SAMPLE_W-1:0]  sample_value_i = '0;
  logic                 sample_ok_i = 1'b0;
  logic                 last_i = 1'b0;
  logic                 done_o;
  logic                 stats_valid_o;
  logic [CNT_OUT_W-1:0] error_count_o;
  logic                 overflowed_o;
  logic [CNT_OUT_W-1:0] sample_count_o;
  logic [SAMPLE_W-1:0]  largest_o;
  logic [SAMPLE_W-1:0]  mean_value_o;
  logic [VAR_W-1:0]     variance_value_o;
  logic [SAMPLE_W-1:0]  median_value_o;

  series_mean_variance_median_unit #(.MAX_SAMPLES(DEPTH)) DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sample_item_t  pending_samples[$];
  series_stats_t expected_stats[$];
  int unsigned   failures = 0;
  int unsigned   samples_taken = 0;
  int unsigned   series_checked = 0;
  int unsigned   valid_series = 0;

  // running series state of the predictor
  logic [SAMPLE_W-1:0] kept[$];
  longint unsigned     acc_sum;
  logic [SAMPLE_W-1:0] acc_max;
  int unsigned         acc_bad;
  bit                  acc_ovf;

  task automatic clear_series_state();
    kept.delete();
    acc_sum = 0;
    acc_max = '0;
    acc_bad = 0;
    acc_ovf = 1'b0;
  endtask

  task automatic absorb_sample(logic [SAMPLE_W-1:0] v, bit ok, bit lst);
    series_stats_t   r;
    longint unsigned n, m, d, vsum;
    logic [SAMPLE_W-1:0] srt[$];
    logic [SAMPLE_W:0]   pair;
    if (ok) begin
      if (kept.size() < DEPTH) begin
        kept = {kept, v};
        acc_sum += v;
        if (v > acc_max) acc_max = v;
      end else begin
        acc_ovf = 1'b1;
      end
    end else if (acc_bad < 511) begin
      acc_bad++;
    end
    if (lst) begin
      n = kept.size();
      r.valid  = (acc_bad == 0) && (n > 0) && !acc_ovf;
      r.errors = acc_bad[CNT_OUT_W-1:0];
      r.ovf    = acc_ovf;
      r.count  = n[CNT_OUT_W-1:0];
      r.maxv = '0; r.mean = '0; r.var_v = '0; r.med = '0;
      if (r.valid) begin
        m = acc_sum / n;
        vsum = 0;
        foreach (kept[i]) begin
          d = (kept[i] >= m) ? kept[i] - m : m - kept[i];
          vsum += d * d;
        end
        srt = kept;
        srt.sort();
        r.maxv  = acc_max;
        r.mean  = m[SAMPLE_W-1:0];
        r.var_v = VAR_W'(vsum / n);
        if (n % 2 == 0) begin
          pair  = {1'b0, srt[n/2]} + {1'b0, srt[n/2-1]};
          r.med = pair[SAMPLE_W:1];
        end else begin
          r.med = srt[n/2];
        end
        valid_series++;
      end
      expected_stats = {expected_stats, r};
      clear_series_state();
    end
  endtask

  // monitor: checks results and records accepted transactions
  always @(posedge clk_i) begin
    series_stats_t e;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_stats.size() == 0) begin
          $error("result with nothing expected");
          failures++;
        end else begin
          e = expected_stats.pop_front();
          series_checked++;
          if (stats_valid_o !== e.valid) begin
            $error("stats_valid exp %0d got %0d", e.valid, stats_valid_o); failures++;
          end
          if (error_count_o !== e.errors) begin
            $error("error_count exp %0d got %0d", e.errors, error_count_o); failures++;
          end
          if (overflowed_o !== e.ovf) begin
            $error("overflowed exp %0d got %0d", e.ovf, overflowed_o); failures++;
          end
          if (sample_count_o !== e.count) begin
            $error("sample_count exp %0d got %0d", e.count, sample_count_o); failures++;
          end
          if (largest_o !== e.maxv) begin
            $error("largest exp %h got %h", e.maxv, largest_o); failures++;
          end
          if (mean_value_o !== e.mean) begin
            $error("mean_value exp %h got %h", e.mean, mean_value_o); failures++;
          end
          if (variance_value_o !== e.var_v) begin
            $error("variance_value exp %h got %h", e.var_v, variance_value_o); failures++;
          end
          if (median_value_o !== e.med) begin
            $error("median_value exp %h got %h", e.med, median_value_o); failures++;
          end
        end
      end
      if (start_i && !busy_o) begin
        absorb_sample(sample_value_i, sample_ok_i, last_i);
        void'(pending_samples.pop_front());
        samples_taken++;
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    bit idle;
    idle = ($urandom_range(99) < 23) && !(samples_taken > 600 && samples_taken < 850);
    if (!rst_ni || pending_samples.size() == 0 || idle ||
        (pending_samples[0].hold && expected_stats.size() != 0)) begin
      start_i <= 1'b0;
    end else begin
      start_i        <= 1'b1;
      sample_value_i <= pending_samples[0].value;
      sample_ok_i    <= pending_samples[0].ok;
      last_i         <= pending_samples[0].lst;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(255);
      3: return {1'b1, 23'($urandom)};
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic queue_sample(logic [SAMPLE_W-1:0] v, bit ok, bit lst, bit hold = 1'b0);
    sample_item_t it;
    it.value = v; it.ok = ok; it.lst = lst; it.hold = hold;
    pending_samples = {pending_samples, it};
  endtask

  // bad_pct: chance in percent of an invalid sample
  task automatic queue_series(int unsigned len, int unsigned bad_pct, bit hold);
    for (int unsigned i = 0; i < len; i++)
      queue_sample(rand_value(), $urandom_range(99) >= bad_pct, i == len - 1,
                   hold && i == 0);
  endtask

  initial begin
    int unsigned len;
    clear_series_state();
    // directed
    queue_sample('0, 1, 1);
    queue_sample('1, 1, 1);
    queue_sample('1, 1, 0); queue_sample(24'hFFFFFE, 1, 1);
    queue_sample(24'h000300, 1, 0); queue_sample(24'h000100, 1, 0);
    queue_sample(24'h000200, 1, 1);
    queue_sample('1, 0, 1);
    queue_sample(24'h00ABCD, 0, 1);
    queue_sample(24'h000010, 1, 0); queue_sample('1, 0, 0); queue_sample(24'h20, 1, 1);
    queue_sample('0, 1, 0); queue_sample('1, 1, 0); queue_sample('0, 1, 0);
    queue_sample('1, 1, 1, 1'b1);
    queue_sample(24'h000005, 1, 0); queue_sample(24'h000005, 1, 1);
    // store exactly full, then overflowing, then saturating error count
    for (int i = 0; i < DEPTH; i++) queue_sample(rand_value(), 1, i == DEPTH - 1);
    for (int i = 0; i < DEPTH + 3; i++) queue_sample(rand_value(), 1, i == DEPTH + 2);
    for (int i = 0; i < 515; i++) queue_sample(rand_value(), 0, i == 514);
    // random series, mostly clean and short
    while (pending_samples.size() < 1450) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      if ($urandom_range(99) < 80) queue_series(len, 0, $urandom_range(29) == 0);
      else queue_series(len, $urandom_range(60, 5), 1'b0);
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_samples.size() == 0 && expected_stats.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d samples sent, %0d series checked (%0d valid), incl. full store,",
             samples_taken, series_checked, valid_series);
    $display("overflow, saturated error count and series with invalid samples.");
    if (failures == 0 && expected_stats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

endmodule
